// ===== rtl/core/tgr_pkg.sv =====
`timescale 1ns / 1ps
// shared types, codes and constants of the trilinear grid resampler
// no dependencies
package tgr_pkg;

  // grid defaults and store geometry
  localparam int DEF_GRID_NX = 64;
  localparam int DEF_GRID_NY = 64;
  localparam int DEF_GRID_NZ = 32;
  localparam int STORE_DEPTH = 131072;
  localparam int ADDR_W = 17;
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SAMPLE = 1'b1
  } tgr_op_t;

  typedef enum logic [1:0] {
    ST_VALID   = 2'd0,
    ST_OUTSIDE = 2'd1,
    ST_MISSING = 2'd2
  } tgr_status_t;

  typedef enum logic [2:0] {
    CFG_ORIGIN_X  = 3'd0,
    CFG_ORIGIN_Y  = 3'd1,
    CFG_ORIGIN_Z  = 3'd2,
    CFG_SPACING_X = 3'd3,
    CFG_SPACING_Y = 3'd4,
    CFG_SPACING_Z = 3'd5
  } tgr_cfg_idx_t;

  // input word
  typedef struct packed {
    logic                     op;
    logic [ADDR_W-1:0]        voxel_addr;
    logic signed [15:0]       voxel_dbz;
    logic                     voxel_valid;
    logic signed [19:0]       pos_x;
    logic signed [19:0]       pos_y;
    logic signed [19:0]       pos_z;
  } tgr_in_t;

  // result word
  typedef struct packed {
    logic signed [15:0] sample_dbz;
    logic [1:0]         sample_status;
  } tgr_out_t;

  // configuration registers
  typedef struct packed {
    logic signed [19:0] origin_x;
    logic signed [19:0] origin_y;
    logic signed [19:0] origin_z;
    logic [15:0]        spacing_x;
    logic [15:0]        spacing_y;
    logic [15:0]        spacing_z;
  } tgr_cfg_t;

  // classified job handed from front to back
  typedef struct packed {
    logic               is_sample;
    logic               outside;
    logic [ADDR_W-1:0]  addr;
    logic signed [15:0] dbz;
    logic               vvalid;
    logic [16:0]        fx;
    logic [16:0]        fy;
    logic [16:0]        fz;
  } tgr_job_t;

endpackage

// ===== rtl/core/tgr_front.sv =====
`timescale 1ns / 1ps
// front end: takes words, range checks each axis, pipelined cell/fraction division
// depends on tgr_pkg
module tgr_front #(
  parameter int GRID_NX = tgr_pkg::DEF_GRID_NX,
  parameter int GRID_NY = tgr_pkg::DEF_GRID_NY,
  parameter int GRID_NZ = tgr_pkg::DEF_GRID_NZ
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic              in_valid,
  input  tgr_pkg::tgr_in_t  in_item,
  input  tgr_pkg::tgr_cfg_t cfg,
  output logic              out_valid,
  output tgr_pkg::tgr_job_t out_job
);
  import tgr_pkg::*;

  localparam int NMAX0 = (GRID_NX > GRID_NY) ? GRID_NX : GRID_NY;
  localparam int NMAX = (NMAX0 > GRID_NZ) ? NMAX0 : GRID_NZ;
  localparam int QB = (NMAX > 2) ? $clog2(NMAX) : 1;
  localparam int QW = QB + 16;
  localparam int LW = QB + 16;
  localparam int CW = (LW > 20) ? LW : 20;
  localparam int NX_A = GRID_NX % STORE_DEPTH;
  localparam int NXY_A = (GRID_NX * GRID_NY) % STORE_DEPTH;

  typedef struct packed {
    logic               vld;
    logic               op;
    logic               outside;
    logic [ADDR_W-1:0]  addr;
    logic signed [15:0] dbz;
    logic               vvalid;
  } ctl_t;

  typedef struct packed {
    logic [15:0]   rem;
    logic [QW-1:0] dvd;
    logic [QW-1:0] quo;
  } div_t;

  // per-axis views of input and config
  logic signed [19:0] pos [3];
  logic signed [19:0] org [3];
  logic [15:0]        sp  [3];
  logic [20:0]        off_next [3];
  logic [LW-1:0]      lim_next [3];

  // stage 0 registers
  logic          s0_vld;
  tgr_in_t       s0_item;
  logic [20:0]   s0_off [3];
  logic [LW-1:0] s0_lim [3];

  // division pipeline registers, index 0 is the set-up stage
  ctl_t dv_ctl [QW+1];
  div_t dv_ax  [QW+1][3];

  // stage 1 set-up values
  ctl_t ctl_init;
  div_t ax_init [3];
  logic out_any;

  always_comb begin
    pos[0] = in_item.pos_x;
    pos[1] = in_item.pos_y;
    pos[2] = in_item.pos_z;
    org[0] = cfg.origin_x;
    org[1] = cfg.origin_y;
    org[2] = cfg.origin_z;
    sp[0] = (cfg.spacing_x == 16'd0) ? 16'd1 : cfg.spacing_x;
    sp[1] = (cfg.spacing_y == 16'd0) ? 16'd1 : cfg.spacing_y;
    sp[2] = (cfg.spacing_z == 16'd0) ? 16'd1 : cfg.spacing_z;
  end

  // offset from origin and upper limit per axis
  for (genvar a = 0; a < 3; a++) begin : g_s0
    localparam int N = (a == 0) ? GRID_NX : ((a == 1) ? GRID_NY : GRID_NZ);
    assign off_next[a] = {pos[a][19], pos[a]} - {org[a][19], org[a]};
    assign lim_next[a] = LW'(N - 1) * LW'(sp[a]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_vld <= 1'b0;
    end else if (adv) begin
      s0_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_item <= in_item;
      s0_off <= off_next;
      s0_lim <= lim_next;
    end
  end

  // range check and divider set-up
  always_comb begin
    logic [QB+35:0] offe;
    logic [19:0]    off_u;
    out_any = 1'b0;
    for (int a = 0; a < 3; a++) begin
      off_u = s0_off[a][19:0];
      offe = (QB + 36)'(off_u);
      if (s0_off[a][20] || (CW'(off_u) > CW'(s0_lim[a]))) begin
        out_any = 1'b1;
      end
      ax_init[a].rem = offe[QB +: 16];
      ax_init[a].dvd = {off_u[QB-1:0], 16'd0};
      ax_init[a].quo = '0;
    end
    ctl_init.vld = s0_vld;
    ctl_init.op = s0_item.op;
    ctl_init.outside = out_any;
    ctl_init.addr = s0_item.voxel_addr;
    ctl_init.dbz = s0_item.voxel_dbz;
    ctl_init.vvalid = s0_item.voxel_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_ctl[0] <= '0;
    end else if (adv) begin
      dv_ctl[0] <= ctl_init;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_ax[0] <= ax_init;
    end
  end

  // one quotient bit per stage, off * 65536 / spacing
  for (genvar k = 0; k < QW; k++) begin : g_div
    div_t nxt [3];

    always_comb begin
      logic [16:0] r17;
      logic        ge;
      for (int a = 0; a < 3; a++) begin
        r17 = {dv_ax[k][a].rem, dv_ax[k][a].dvd[QW-1]};
        ge = (r17 >= {1'b0, sp[a]});
        nxt[a].rem = ge ? 16'(r17 - {1'b0, sp[a]}) : r17[15:0];
        nxt[a].dvd = {dv_ax[k][a].dvd[QW-2:0], 1'b0};
        nxt[a].quo = {dv_ax[k][a].quo[QW-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_ctl[k+1] <= '0;
      end else if (adv) begin
        dv_ctl[k+1] <= dv_ctl[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_ax[k+1] <= nxt;
      end
    end
  end

  // upper edge fix, base address of the cell
  logic [QB-1:0]     cell_idx [3];
  logic [16:0]       frac [3];
  logic [ADDR_W-1:0] base;

  for (genvar a = 0; a < 3; a++) begin : g_fin
    localparam int N = (a == 0) ? GRID_NX : ((a == 1) ? GRID_NY : GRID_NZ);
    logic [QB-1:0] c;
    assign c = dv_ax[QW][a].quo[QW-1:16];
    assign cell_idx[a] = (c == QB'(N - 1)) ? QB'(N - 2) : c;
    assign frac[a] = (c == QB'(N - 1)) ? 17'h10000 : {1'b0, dv_ax[QW][a].quo[15:0]};
  end

  assign base = ADDR_W'(cell_idx[2]) * ADDR_W'(NXY_A) + ADDR_W'(cell_idx[1]) * ADDR_W'(NX_A)
              + ADDR_W'(cell_idx[0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= dv_ctl[QW].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_job.is_sample <= (dv_ctl[QW].op == OP_SAMPLE);
      out_job.outside <= dv_ctl[QW].outside;
      out_job.addr <= (dv_ctl[QW].op == OP_SAMPLE) ? base : dv_ctl[QW].addr;
      out_job.dbz <= dv_ctl[QW].dbz;
      out_job.vvalid <= dv_ctl[QW].vvalid;
      out_job.fx <= frac[0];
      out_job.fy <= frac[1];
      out_job.fz <= frac[2];
    end
  end

endmodule

// ===== rtl/core/tgr_queue.sv =====
`timescale 1ns / 1ps
// short job queue between front and back end
// depends on tgr_pkg
module tgr_queue #(
  parameter int DEPTH = tgr_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  tgr_pkg::tgr_job_t push_job,
  input  logic              pop,
  output logic              full,
  output logic              nonempty,
  output tgr_pkg::tgr_job_t head
);
  import tgr_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  tgr_job_t       slots [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CNTW-1:0] count;
  logic           do_push;
  logic           do_pop;

  assign full = (count == CNTW'(DEPTH));
  assign nonempty = (count != '0);
  assign do_push = push && !full;
  assign do_pop = pop && nonempty;
  assign head = slots[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // slot storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

endmodule

// ===== rtl/core/tgr_back.sv =====
`timescale 1ns / 1ps
// back end: voxel store (eight copies, one per corner), corner check, x/y/z blending
// depends on tgr_pkg
module tgr_back #(
  parameter int GRID_NX = tgr_pkg::DEF_GRID_NX,
  parameter int GRID_NY = tgr_pkg::DEF_GRID_NY
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  tgr_pkg::tgr_job_t in_job,
  output logic              res_strobe,
  output tgr_pkg::tgr_out_t res
);
  import tgr_pkg::*;

  localparam int NX_A = GRID_NX % STORE_DEPTH;
  localparam int NXY_A = (GRID_NX * GRID_NY) % STORE_DEPTH;

  // one linear blend: a + ((b - a) * f + half) >> 16, floor
  function automatic logic signed [15:0] lerp(input logic signed [15:0] a,
                                               input logic signed [15:0] b,
                                               input logic [16:0] f);
    logic signed [16:0] d;
    logic signed [17:0] fs;
    logic signed [34:0] p;
    logic signed [34:0] s;
    d = {b[15], b} - {a[15], a};
    fs = $signed({1'b0, f});
    p = 35'(d) * 35'(fs);
    s = (p + 35'sd32768) >>> 16;
    return a + s[15:0];
  endfunction

  logic [ADDR_W-1:0] caddr [8];
  logic [16:0]       rd [8];
  logic              we;

  assign we = in_valid && !in_job.is_sample;

  // corner addresses, wrapping at the store depth
  for (genvar k = 0; k < 8; k++) begin : g_mem
    logic [16:0] mem [STORE_DEPTH];
    assign caddr[k] = in_job.addr + (((k & 1) != 0) ? ADDR_W'(1) : '0)
                    + (((k & 2) != 0) ? ADDR_W'(NX_A) : '0)
                    + (((k & 4) != 0) ? ADDR_W'(NXY_A) : '0);

    always_ff @(posedge clk) begin
      if (we) begin
        mem[in_job.addr] <= {in_job.vvalid, in_job.dbz};
      end
      rd[k] <= mem[caddr[k]];
    end
  end

  // corner read stage
  logic     b1_vld;
  tgr_job_t b1_job;

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_vld <= 1'b0;
    end else begin
      b1_vld <= in_valid && in_job.is_sample;
    end
  end

  always_ff @(posedge clk) begin
    b1_job <= in_job;
  end

  // blend along x, check corners
  logic               b2_vld;
  logic               b2_outside;
  logic               b2_missing;
  logic [16:0]        b2_fy;
  logic [16:0]        b2_fz;
  logic signed [15:0] b2_v [4];
  logic               missing;

  always_comb begin
    missing = 1'b0;
    for (int k = 0; k < 8; k++) begin
      if (!rd[k][16]) begin
        missing = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b2_vld <= 1'b0;
    end else begin
      b2_vld <= b1_vld;
    end
  end

  always_ff @(posedge clk) begin
    b2_outside <= b1_job.outside;
    b2_missing <= missing;
    b2_fy <= b1_job.fy;
    b2_fz <= b1_job.fz;
    b2_v[0] <= lerp(rd[0][15:0], rd[1][15:0], b1_job.fx);
    b2_v[1] <= lerp(rd[2][15:0], rd[3][15:0], b1_job.fx);
    b2_v[2] <= lerp(rd[4][15:0], rd[5][15:0], b1_job.fx);
    b2_v[3] <= lerp(rd[6][15:0], rd[7][15:0], b1_job.fx);
  end

  // blend along y
  logic               b3_vld;
  logic               b3_outside;
  logic               b3_missing;
  logic [16:0]        b3_fz;
  logic signed [15:0] b3_lo;
  logic signed [15:0] b3_hi;

  always_ff @(posedge clk) begin
    if (rst) begin
      b3_vld <= 1'b0;
    end else begin
      b3_vld <= b2_vld;
    end
  end

  always_ff @(posedge clk) begin
    b3_outside <= b2_outside;
    b3_missing <= b2_missing;
    b3_fz <= b2_fz;
    b3_lo <= lerp(b2_v[0], b2_v[1], b2_fy);
    b3_hi <= lerp(b2_v[2], b2_v[3], b2_fy);
  end

  // blend along z, status and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_strobe <= 1'b0;
    end else begin
      res_strobe <= b3_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (b3_outside) begin
      res.sample_dbz <= '0;
      res.sample_status <= ST_OUTSIDE;
    end else if (b3_missing) begin
      res.sample_dbz <= '0;
      res.sample_status <= ST_MISSING;
    end else begin
      res.sample_dbz <= lerp(b3_lo, b3_hi, b3_fz);
      res.sample_status <= ST_VALID;
    end
  end

endmodule

// ===== rtl/core/trilinear_grid_resampler_unit.sv =====
`timescale 1ns / 1ps
// path to the result strobe: input register, divider set-up, one-bit-per-stage cell/fraction divider,
// front output register, job queue, corner read, x blend, y blend, z blend and output register
// throughput: one word per cycle, writes and samples alike; busy only rises if the job
// queue fills; results cannot be stalled, a sample gives one strobe, a write none
// reset: synchronous, clears pipeline valids and queue, sets config to defaults; voxel store is not cleared
// top level: config registers, front end, job queue, back end; depends on tgr_pkg
module trilinear_grid_resampler_unit #(
  parameter int GRID_NX = tgr_pkg::DEF_GRID_NX,
  parameter int GRID_NY = tgr_pkg::DEF_GRID_NY,
  parameter int GRID_NZ = tgr_pkg::DEF_GRID_NZ
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  tgr_pkg::tgr_in_t  item,
  output logic              result_strobe,
  output tgr_pkg::tgr_out_t result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [19:0]       cfg_data
);
  import tgr_pkg::*;

  tgr_cfg_t cfg;
  logic     q_full;
  logic     q_nonempty;
  logic     fe_valid;
  tgr_job_t fe_job;
  tgr_job_t q_head;
  logic     adv;

  assign cfg_ready = 1'b1;
  assign busy = q_full;
  assign adv = !q_full;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.origin_x <= '0;
      cfg.origin_y <= '0;
      cfg.origin_z <= '0;
      cfg.spacing_x <= 16'd1000;
      cfg.spacing_y <= 16'd1000;
      cfg.spacing_z <= 16'd500;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ORIGIN_X:  cfg.origin_x <= cfg_data;
        CFG_ORIGIN_Y:  cfg.origin_y <= cfg_data;
        CFG_ORIGIN_Z:  cfg.origin_z <= cfg_data;
        CFG_SPACING_X: cfg.spacing_x <= cfg_data[15:0];
        CFG_SPACING_Y: cfg.spacing_y <= cfg_data[15:0];
        CFG_SPACING_Z: cfg.spacing_z <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // range check and cell/fraction division
  tgr_front #(
    .GRID_NX(GRID_NX),
    .GRID_NY(GRID_NY),
    .GRID_NZ(GRID_NZ)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .adv(adv),
    .in_valid(start && !busy),
    .in_item(item),
    .cfg(cfg),
    .out_valid(fe_valid),
    .out_job(fe_job)
  );

  // decoupling queue
  tgr_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .push(fe_valid && adv),
    .push_job(fe_job),
    .pop(q_nonempty),
    .full(q_full),
    .nonempty(q_nonempty),
    .head(q_head)
  );

  // voxel store and blending
  tgr_back #(
    .GRID_NX(GRID_NX),
    .GRID_NY(GRID_NY)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .in_valid(q_nonempty),
    .in_job(q_head),
    .res_strobe(result_strobe),
    .res(result)
  );

endmodule

// ===== tb/tb_trilinear_grid_resampler_unit.sv =====
`timescale 1ns / 1ps
// self-checking bench for trilinear_grid_resampler_unit: voxel writes, sample points, register phases
// depends on tgr_pkg and the rtl top level; builds its own grid interpolator to predict results

// predicts sample results and checks them against the block's output words
class tgr_scoreboard;
  localparam longint NX = tgr_pkg::DEF_GRID_NX;
  localparam longint NY = tgr_pkg::DEF_GRID_NY;
  localparam longint NZ = tgr_pkg::DEF_GRID_NZ;
  localparam longint ONE = 65536;

  logic [16:0]          voxels [tgr_pkg::STORE_DEPTH];
  logic signed [19:0]   origin [3];
  logic [15:0]          spacing [3];
  tgr_pkg::tgr_out_t    pending_samples [$];
  int                   n_errors;
  int                   n_writes;
  int                   n_status [3];

  function new();
    origin[0] = '0;
    origin[1] = '0;
    origin[2] = '0;
    spacing[0] = 16'd1000;
    spacing[1] = 16'd1000;
    spacing[2] = 16'd500;
    n_errors = 0;
    n_writes = 0;
    n_status = '{0, 0, 0};
  endfunction

  function void set_reg(tgr_pkg::tgr_cfg_idx_t idx, logic [19:0] d);
    case (idx)
      tgr_pkg::CFG_ORIGIN_X:  origin[0] = d;
      tgr_pkg::CFG_ORIGIN_Y:  origin[1] = d;
      tgr_pkg::CFG_ORIGIN_Z:  origin[2] = d;
      tgr_pkg::CFG_SPACING_X: spacing[0] = d[15:0];
      tgr_pkg::CFG_SPACING_Y: spacing[1] = d[15:0];
      default:                spacing[2] = d[15:0];
    endcase
  endfunction

  function longint eff_spacing(int ax);
    return (spacing[ax] == 0) ? 1 : longint'(spacing[ax]);
  endfunction

  function longint axis_size(int ax);
    return (ax == 0) ? NX : (ax == 1) ? NY : NZ;
  endfunction

  // cell and fraction (16 fraction bits, 65536 at the upper edge) along one axis; 0 when the point lies off the grid
  function bit find_cell(int ax, longint pos, output longint cell_idx, output longint frac);
    longint sp;
    longint off;
    longint n;
    longint c;
    sp = eff_spacing(ax);
    n = axis_size(ax);
    off = pos - longint'(origin[ax]);
    cell_idx = 0;
    frac = 0;
    if (off < 0 || off > (n - 1) * sp) return 0;
    c = off / sp;
    if (c >= n - 1) begin
      cell_idx = n - 2;
      frac = ONE;
    end else begin
      cell_idx = c;
      frac = ((off - c * sp) * ONE) / sp;
    end
    return 1;
  endfunction

  // flat store address of corner k of the cell at (ix, iy, iz)
  function logic [16:0] corner_addr(longint ix, longint iy, longint iz, int k);
    longint a;
    a = iz * NX * NY + iy * NX + ix;
    if (k[0]) a += 1;
    if (k[1]) a += NX;
    if (k[2]) a += NX * NY;
    return a[16:0];
  endfunction

  // rounded blend of a and b, ties going up
  function longint blend(longint a, longint b, longint f);
    longint s;
    s = a * (ONE - f) + b * f + 32768;
    return s >>> 16;
  endfunction

  function tgr_pkg::tgr_out_t interpolate(tgr_pkg::tgr_in_t w);
    tgr_pkg::tgr_out_t r;
    longint ix, iy, iz, fx, fy, fz;
    longint v [8];
    longint lo, hi;
    logic [16:0] e;
    r.sample_dbz = '0;
    if (!find_cell(0, longint'(w.pos_x), ix, fx) || !find_cell(1, longint'(w.pos_y), iy, fy) ||
        !find_cell(2, longint'(w.pos_z), iz, fz)) begin
      r.sample_status = tgr_pkg::ST_OUTSIDE;
      return r;
    end
    for (int k = 0; k < 8; k++) begin
      e = voxels[corner_addr(ix, iy, iz, k)];
      if (e[16] !== 1'b1) begin
        r.sample_status = tgr_pkg::ST_MISSING;
        return r;
      end
      v[k] = longint'($signed(e[15:0]));
    end
    lo = blend(blend(v[0], v[1], fx), blend(v[2], v[3], fx), fy);
    hi = blend(blend(v[4], v[5], fx), blend(v[6], v[7], fx), fy);
    r.sample_dbz = 16'(blend(lo, hi, fz));
    r.sample_status = tgr_pkg::ST_VALID;
    return r;
  endfunction

  // accepted input word: store a voxel or queue the predicted sample
  function void note_word(tgr_pkg::tgr_in_t w);
    tgr_pkg::tgr_out_t r;
    if (w.op == tgr_pkg::OP_WRITE) begin
      voxels[w.voxel_addr] = {w.voxel_valid, w.voxel_dbz};
      n_writes++;
    end else begin
      r = interpolate(w);
      n_status[r.sample_status]++;
      pending_samples.push_back(r);
    end
  endfunction

  function void check_result(tgr_pkg::tgr_out_t got);
    tgr_pkg::tgr_out_t want;
    if (pending_samples.size() == 0) begin
      $error("result word with none expected: dbz %0d status %0d",
             got.sample_dbz, got.sample_status);
      n_errors++;
      return;
    end
    want = pending_samples.pop_front();
    if (got.sample_dbz !== want.sample_dbz) begin
      $error("sample_dbz: expected %0d, actual %0d", want.sample_dbz, got.sample_dbz);
      n_errors++;
    end
    if (got.sample_status !== want.sample_status) begin
      $error("sample_status: expected %0d, actual %0d", want.sample_status, got.sample_status);
      n_errors++;
    end
  endfunction
endclass

module tb_trilinear_grid_resampler_unit;
  import tgr_pkg::*;

  localparam int DRAIN_CYCLES = 40;
  localparam int IN_W = $bits(tgr_in_t);

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  tgr_in_t     item = '0;
  logic        result_strobe;
  tgr_out_t    result;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [19:0] cfg_data = '0;

  tgr_scoreboard sb = new();
  bit            written [STORE_DEPTH];
  bit            idle_on = 1'b1;
  int            n_phases = 0;

  trilinear_grid_resampler_unit i_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .item(item),
    .result_strobe(result_strobe),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // clock
  always #4 clk = ~clk;

  // result monitor
  always @(posedge clk) begin
    if (!rst && result_strobe) sb.check_result(result);
  end

  // hand one word over and hold it until the block takes it
  task automatic send_word(tgr_in_t w);
    start <= 1'b1;
    item <= w;
    do @(posedge clk); while (busy);
    sb.note_word(w);
  endtask

  // occasional random sender gap, while gaps are enabled
  task automatic maybe_gap();
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic write_voxel(logic [16:0] addr, logic signed [15:0] dbz, logic vld);
    tgr_in_t w;
    logic [95:0] rnd;
    rnd = {$urandom, $urandom, $urandom};
    w = tgr_in_t'(rnd[IN_W-1:0]);
    w.op = OP_WRITE;
    w.voxel_addr = addr;
    w.voxel_dbz = dbz;
    w.voxel_valid = vld;
    written[addr] = 1'b1;
    send_word(w);
  endtask

  // sample a point, first filling any corner never written (and some at random)
  task automatic sample_point(longint px, longint py, longint pz);
    tgr_in_t w;
    logic [95:0] rnd;
    longint ix, iy, iz, f;
    logic [16:0] a;
    if (sb.find_cell(0, px, ix, f) && sb.find_cell(1, py, iy, f) &&
        sb.find_cell(2, pz, iz, f)) begin
      for (int k = 0; k < 8; k++) begin
        a = sb.corner_addr(ix, iy, iz, k);
        if (!written[a] || $urandom_range(0, 5) == 0)
          write_voxel(a, 16'($urandom), $urandom_range(0, 11) != 0);
      end
    end
    rnd = {$urandom, $urandom, $urandom};
    w = tgr_in_t'(rnd[IN_W-1:0]);
    w.op = OP_SAMPLE;
    w.pos_x = 20'(px);
    w.pos_y = 20'(py);
    w.pos_z = 20'(pz);
    send_word(w);
  endtask

  // coordinate along one axis: mostly on the grid, sometimes at or past its limits
  function automatic longint pick_coord(int ax);
    longint org, sp, top, p;
    int mode;
    org = longint'(sb.origin[ax]);
    sp = sb.eff_spacing(ax);
    top = org + (sb.axis_size(ax) - 1) * sp;
    mode = $urandom_range(0, 29);
    case (mode)
      0:       p = longint'($signed(20'($urandom)));
      1:       p = org - $urandom_range(1, 3);
      2:       p = top;
      3:       p = top + $urandom_range(1, 3);
      4:       p = org;
      default: p = org + longint'($urandom_range(0, 32'((top - org))));
    endcase
    if (p < -524288 || p > 524287) p = longint'($signed(20'($urandom)));
    return p;
  endfunction

  // let the pipeline empty, then write all six registers
  task automatic load_setting(logic [19:0] ox, logic [19:0] oy, logic [19:0] oz,
                              logic [15:0] sx, logic [15:0] sy, logic [15:0] sz);
    logic [19:0] vals [6];
    vals = '{ox, oy, oz, 20'(sx), 20'(sy), 20'(sz)};
    start <= 1'b0;
    while (sb.pending_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    for (int i = 0; i < 6; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      sb.set_reg(tgr_cfg_idx_t'(i), vals[i]);
    end
    cfg_valid <= 1'b0;
    n_phases++;
  endtask

  task automatic random_items(int n, int quiet_from);
    for (int i = 0; i < n; i++) begin
      if (i >= quiet_from) idle_on = 1'b0;
      if ($urandom_range(0, 99) < 25)
        write_voxel(17'($urandom), 16'($urandom), $urandom_range(0, 4) != 0);
      else
        sample_point(pick_coord(0), pick_coord(1), pick_coord(2));
      maybe_gap();
    end
  endtask

  // stimulus
  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: value extremes on cell zero, limits of the grid, missing corner
    for (int k = 0; k < 8; k++)
      write_voxel(sb.corner_addr(0, 0, 0, k), k[0] ? 16'sh8000 : 16'sh7fff, 1'b1);
    sample_point(0, 0, 0);
    sample_point(500, 500, 250);
    sample_point(999, 999, 499);
    sample_point(1, 0, 0);
    write_voxel(17'h1ffff, 16'sh7fff, 1'b1);
    sample_point(63000, 63000, 15500);
    sample_point(62999, 63000, 15499);
    sample_point(-1, 0, 0);
    sample_point(63001, 0, 0);
    sample_point(0, 0, 15501);
    sample_point(-524288, -524288, -524288);
    sample_point(524287, 524287, 524287);
    write_voxel(17'd0, 16'sd0, 1'b0);
    sample_point(0, 0, 0);
    sample_point(500, 0, 0);

    // hold the sender off until every sample is back
    start <= 1'b0;
    while (sb.pending_samples.size() != 0) @(posedge clk);

    random_items(45, 45);
    load_setting(20'h80000, 20'h80000, 20'h80000, 16'd1, 16'd1, 16'd1);
    sample_point(-524288, -524288, -524288);
    sample_point(-524288 + 63, -524288 + 63, -524288 + 31);
    random_items(45, 45);
    load_setting(20'h7ffff, 20'h7ffff, 20'h7ffff, 16'hffff, 16'hffff, 16'hffff);
    random_items(150, 150);
    load_setting(20'(-3000), 20'(-77), 20'(5), 16'd0, 16'd7, 16'd3);
    random_items(45, 45);
    load_setting(20'($urandom_range(0, 2000) - 1000), 20'($urandom_range(0, 2000) - 1000),
                 20'($urandom_range(0, 2000) - 1000), 16'($urandom_range(1, 2000)),
                 16'($urandom_range(1, 2000)), 16'($urandom_range(1, 2000)));
    random_items(55, 55);
    load_setting(20'(-20000), 20'(-20000), 20'(0), 16'd1000, 16'd1000, 16'd500);
    random_items(55, 0);

    // drain
    start <= 1'b0;
    while (sb.pending_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d voxel writes and %0d samples over %0d register settings",
             sb.n_writes, sb.n_status[0] + sb.n_status[1] + sb.n_status[2], n_phases);
    $display("samples by outcome: %0d interpolated, %0d off grid, %0d missing corner",
             sb.n_status[0], sb.n_status[1], sb.n_status[2]);
    if (sb.n_errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog
  initial begin
    #6ms;
    $display("timeout with %0d samples outstanding", sb.pending_samples.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
